>>> hw/rtl/rqi_pkg.sv
// ---------------------------------------------------------------------------
// rqi_pkg: shared types and constants for ray_quad_intersect
// Plane packing, ray and result payloads, and the front-to-back job record.
// ---------------------------------------------------------------------------
package rqi_pkg;

    localparam int PlaneCount = 5;
    localparam int EdgeCount  = 4;
    localparam int IdxW       = 3;
    localparam int QuotBits   = 22;   // hit point quotients stay below 2^22
    localparam int DistBits   = 15;
    localparam int DvdW       = 48;   // |r| * num
    localparam int DenW       = 32;
    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = 2;

    localparam logic [IdxW-1:0] CfgFace  = 3'd0;
    localparam logic [IdxW-1:0] CfgEdge1 = 3'd1;
    localparam logic [IdxW-1:0] CfgEdge2 = 3'd2;
    localparam logic [IdxW-1:0] CfgEdge3 = 3'd3;
    localparam logic [IdxW-1:0] CfgEdge4 = 3'd4;

    typedef struct packed {
        logic signed [15:0] off;   // Q8.8
        logic signed [15:0] nz;    // Q1.14
        logic signed [15:0] ny;
        logic signed [15:0] nx;
    } t_plane;

    typedef struct packed {
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic signed [15:0] origin_z;
        logic signed [15:0] ray_dx;
        logic signed [15:0] ray_dy;
        logic signed [15:0] ray_dz;
        logic        [14:0] max_distance;
    } t_ray;

    typedef struct packed {
        logic               hit;
        logic        [14:0] distance;
        logic signed [15:0] hit_x;
        logic signed [15:0] hit_y;
        logic signed [15:0] hit_z;
    } t_result;

    // dividend 0..2: |r| * num per axis, dividend 3: num * 256 for distance
    typedef struct packed {
        logic                 ok;
        logic [DenW-1:0]      den;
        logic [3:0][DvdW-1:0] dvd;
        logic [2:0]           neg;
        logic [2:0][15:0]     org;
    } t_job;

endpackage

>>> hw/rtl/rqi_if.sv
// ---------------------------------------------------------------------------
// rqi interfaces: ray request, result and configuration write channels
// Valid/ready channels; a request moves on a clock edge with both high.
// ---------------------------------------------------------------------------
interface rqi_ray_if import rqi_pkg::*; ();
    logic valid;
    logic ready;
    t_ray data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface rqi_res_if import rqi_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface rqi_cfg_if import rqi_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [IdxW-1:0] index;
    logic [63:0]     wdata;
    modport source(output valid, output index, output wdata, input ready);
    modport sink(input valid, input index, input wdata, output ready);
endinterface

>>> hw/rtl/rqi_front.sv
// ---------------------------------------------------------------------------
// rqi_front: plane evaluation and classification
// Three stages: products, dot sums, range products; emits one job per ray.
// ---------------------------------------------------------------------------
module rqi_front import rqi_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rqi_ray_if.sink       i_ray,
    input  t_plane        i_face,
    input  logic          i_full,
    output logic          o_push,
    output t_job          o_job
);

    logic en;
    logic r_v1, r_v2, r_v3;

    logic signed [31:0] r_no [3];
    logic signed [31:0] r_nr [3];
    logic signed [15:0] r_d1;
    logic signed [15:0] r_o1 [3];
    logic signed [15:0] r_r1 [3];
    logic        [14:0] r_m1;

    logic signed [33:0] r_num, r_den;
    logic signed [15:0] r_o2 [3];
    logic signed [15:0] r_r2 [3];
    logic        [14:0] r_m2;

    logic                 r_ok3;
    logic [DenW-1:0]      r_den3;
    logic [46:0]          r_rng;
    logic [39:0]          r_n256;
    logic [2:0][DvdW-1:0] r_dvd3;
    logic [2:0]           r_neg3;
    logic [2:0][15:0]     r_o3;

    logic [15:0] abs_r [3];

    assign en          = !(r_v3 && i_full);
    assign i_ray.ready = en;
    assign o_push      = r_v3 && !i_full;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            abs_r[j] = r_r2[j][15] ? 16'(-r_r2[j]) : 16'(r_r2[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_ray.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_no[0] <= i_face.nx * i_ray.data.origin_x;
            r_no[1] <= i_face.ny * i_ray.data.origin_y;
            r_no[2] <= i_face.nz * i_ray.data.origin_z;
            r_nr[0] <= i_face.nx * i_ray.data.ray_dx;
            r_nr[1] <= i_face.ny * i_ray.data.ray_dy;
            r_nr[2] <= i_face.nz * i_ray.data.ray_dz;
            r_d1    <= i_face.off;
            r_o1[0] <= i_ray.data.origin_x;
            r_o1[1] <= i_ray.data.origin_y;
            r_o1[2] <= i_ray.data.origin_z;
            r_r1[0] <= i_ray.data.ray_dx;
            r_r1[1] <= i_ray.data.ray_dy;
            r_r1[2] <= i_ray.data.ray_dz;
            r_m1    <= i_ray.data.max_distance;

            r_num <= 34'(r_no[0]) + 34'(r_no[1]) + 34'(r_no[2]) + (34'(r_d1) <<< 14);
            r_den <= -(34'(r_nr[0]) + 34'(r_nr[1]) + 34'(r_nr[2]));
            r_o2  <= r_o1;
            r_r2  <= r_r1;
            r_m2  <= r_m1;

            // front facing and plane not behind the origin
            r_ok3  <= !r_den[33] && (r_den != '0) && !r_num[33];
            r_den3 <= r_den[DenW-1:0];
            r_rng  <= r_m2 * r_den[DenW-1:0];
            r_n256 <= {r_num[31:0], 8'b0};
            for (int j = 0; j < 3; j++) begin
                r_dvd3[j] <= abs_r[j] * r_num[31:0];
                r_neg3[j] <= r_r2[j][15];
                r_o3[j]   <= r_o2[j];
            end
        end
    end

    // t < max exactly when num*256 < max*den
    always_comb begin
        o_job.ok     = r_ok3 && ({7'b0, r_n256} < r_rng);
        o_job.den    = r_den3;
        o_job.dvd[0] = r_dvd3[0];
        o_job.dvd[1] = r_dvd3[1];
        o_job.dvd[2] = r_dvd3[2];
        o_job.dvd[3] = {8'b0, r_n256};
        o_job.neg    = r_neg3;
        o_job.org    = r_o3;
    end

endmodule

>>> hw/rtl/rqi_queue.sv
// ---------------------------------------------------------------------------
// rqi_queue: job queue between front and back
// Small register FIFO; lets the two halves stall independently.
// ---------------------------------------------------------------------------
module rqi_queue import rqi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    t_job                 r_mem [QueueDepth];
    logic [QueuePtrW-1:0] r_wr, r_rd;
    logic [QueuePtrW:0]   r_cnt;

    assign o_full  = (r_cnt == (QueuePtrW+1)'(QueueDepth));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

>>> hw/rtl/rqi_back.sv
// ---------------------------------------------------------------------------
// rqi_back: quotient pipeline, hit point and edge tests
// One restoring division step per stage for all four quotients, then
// hit point rounding, edge plane products and the result register.
// ---------------------------------------------------------------------------
module rqi_back import rqi_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_job                  i_job,
    input  logic                  i_empty,
    output logic                  o_pop,
    input  t_plane [EdgeCount-1:0] i_edge,
    rqi_res_if.source             o_res
);

    typedef struct packed {
        logic                     ok;
        logic [DenW-1:0]          den;
        logic [3:0][DvdW-1:0]     rem;
        logic [3:0][QuotBits-1:0] q;
        logic [2:0]               neg;
        logic [2:0][15:0]         org;
    } t_div;

    function automatic t_div div_step(t_div d, logic [4:0] k);
        t_div        o;
        logic [53:0] sh;
        o  = d;
        sh = {22'b0, d.den} << k;
        for (int j = 0; j < 4; j++) begin
            if ({6'b0, d.rem[j]} >= sh) begin
                o.rem[j]    = d.rem[j] - sh[DvdW-1:0];
                o.q[j][k]   = 1'b1;
            end
        end
        return o;
    endfunction

    function automatic logic signed [15:0] sat16(logic signed [24:0] v);
        if (v > 25'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -25'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    logic en;
    logic r_sv [QuotBits+1];
    t_div r_st [QuotBits+1];

    logic                    r_v1, r_v2;
    logic                    r_ok1, r_ok2;
    logic [DistBits-1:0]     r_d1, r_d2;
    logic signed [15:0]      r_p1 [3];
    logic signed [15:0]      r_p2 [3];
    logic signed [31:0]      r_ep [EdgeCount][3];
    logic signed [15:0]      r_eo [EdgeCount];

    logic                    r_ov;
    t_result                 r_res;

    logic signed [23:0]      qs [3];
    logic signed [15:0]      p_sat [3];
    logic signed [33:0]      esum [EdgeCount];
    logic                    in_quad;
    t_result                 res_n;

    assign en          = !r_ov || o_res.ready;
    assign o_pop       = en && !i_empty;
    assign o_res.valid = r_ov;
    assign o_res.data  = r_res;

    // stage 0 loads from the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (en) begin
            r_sv[0] <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_st[0].ok  <= i_job.ok;
            r_st[0].den <= i_job.den;
            r_st[0].rem <= i_job.dvd;
            r_st[0].q   <= '0;
            r_st[0].neg <= i_job.neg;
            r_st[0].org <= i_job.org;
        end
    end

    for (genvar s = 0; s < QuotBits; s++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[s+1] <= 1'b0;
            end else if (en) begin
                r_sv[s+1] <= r_sv[s];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_st[s+1] <= div_step(r_st[s], 5'(QuotBits - 1 - s));
            end
        end
    end

    // floor for negative direction components, then origin add and clamp
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            if (r_st[QuotBits].neg[j]) begin
                qs[j] = -($signed({2'b0, r_st[QuotBits].q[j]})
                        + ((r_st[QuotBits].rem[j] != '0) ? 24'sd1 : 24'sd0));
            end else begin
                qs[j] = $signed({2'b0, r_st[QuotBits].q[j]});
            end
            p_sat[j] = sat16(25'($signed(r_st[QuotBits].org[j])) + 25'(qs[j]));
        end
    end

    always_comb begin
        in_quad = 1'b1;
        for (int e = 0; e < EdgeCount; e++) begin
            esum[e] = 34'(r_ep[e][0]) + 34'(r_ep[e][1]) + 34'(r_ep[e][2])
                    + (34'(r_eo[e]) <<< 14);
            if (esum[e][33]) begin
                in_quad = 1'b0;
            end
        end
        if (r_ok2 && in_quad) begin
            res_n.hit      = 1'b1;
            res_n.distance = r_d2;
            res_n.hit_x    = r_p2[0];
            res_n.hit_y    = r_p2[1];
            res_n.hit_z    = r_p2[2];
        end else begin
            res_n = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v1 <= r_sv[QuotBits];
            r_v2 <= r_v1;
            r_ov <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ok1 <= r_st[QuotBits].ok;
            r_d1  <= r_st[QuotBits].q[3][DistBits-1:0];
            r_p1  <= p_sat;

            r_ok2 <= r_ok1;
            r_d2  <= r_d1;
            r_p2  <= r_p1;
            for (int e = 0; e < EdgeCount; e++) begin
                r_ep[e][0] <= i_edge[e].nx * r_p1[0];
                r_ep[e][1] <= i_edge[e].ny * r_p1[1];
                r_ep[e][2] <= i_edge[e].nz * r_p1[2];
                r_eo[e]    <= i_edge[e].off;
            end

            r_res <= res_n;
        end
    end

endmodule

>>> hw/rtl/ray_quad_intersect.sv
// ---------------------------------------------------------------------------
// ray_quad_intersect: ray against convex quad test, fixed point
//
//   channel   dir   payload                              moves when
//   i_ray     in    origin, direction, max_distance      valid && ready
//   o_res     out   hit, distance, hit point             valid && ready
//   i_cfg     in    plane index, 64-bit plane word       valid (ready tied high)
//
// One ray per cycle sustained while o_res.ready stays high; the path runs through
// 3 front stages, the queue, 23 division stages and 3 hit point/edge stages.
// The 22-step restoring divider pipeline sets the depth.
// Reset clears all planes to zero. A stalled result holds the back end;
// the 4-entry queue absorbs the front until it fills, then i_ray.ready drops.
// ---------------------------------------------------------------------------
module ray_quad_intersect import rqi_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rqi_ray_if.sink   i_ray,
    rqi_res_if.source o_res,
    rqi_cfg_if.sink   i_cfg
);

    t_plane r_plane [PlaneCount];
    t_plane [EdgeCount-1:0] edges;

    logic push, pop, full, empty;
    t_job job_in, job_out;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PlaneCount; i++) begin
                r_plane[i] <= '0;
            end
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CfgFace:  r_plane[0] <= i_cfg.wdata;
                CfgEdge1: r_plane[1] <= i_cfg.wdata;
                CfgEdge2: r_plane[2] <= i_cfg.wdata;
                CfgEdge3: r_plane[3] <= i_cfg.wdata;
                CfgEdge4: r_plane[4] <= i_cfg.wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int e = 0; e < EdgeCount; e++) begin
            edges[e] = r_plane[e+1];
        end
    end

    rqi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ray   (i_ray),
        .i_face  (r_plane[0]),
        .i_full  (full),
        .o_push  (push),
        .o_job   (job_in)
    );

    rqi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_full  (full),
        .o_empty (empty)
    );

    rqi_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job_out),
        .i_empty (empty),
        .o_pop   (pop),
        .i_edge  (edges),
        .o_res   (o_res)
    );

endmodule

>>> verif/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: ray against convex quad intersection test bench
// Drives rays with random idle bursts, predicts hit/distance/point from the
// current planes and checks each result in order against the prediction.
// ---------------------------------------------------------------------------
module tb_top;
    import rqi_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always #5 i_clk = ~i_clk;

    rqi_ray_if ray_ch();
    rqi_res_if res_ch();
    rqi_cfg_if cfg_ch();

    ray_quad_intersect DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_ray(ray_ch.sink),
        .o_res(res_ch.source),
        .i_cfg(cfg_ch.sink)
    );

    t_plane   quad_planes [PlaneCount];
    t_result  pending_hits[$];
    int       err_count = 0;
    int       quiet_cycles = 0;
    bit       idle_on = 1'b1;
    bit       done_flag = 1'b0;

    function automatic longint sx(input logic [15:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint plane_at(input t_plane p, input longint x, input longint y,
                                        input longint z, input bit with_off);
        longint acc;
        acc = sx(p.nx) * x + sx(p.ny) * y + sx(p.nz) * z;
        if (with_off) acc += sx(p.off) * 16384;
        return acc;
    endfunction

    function automatic longint fdiv(input longint a, input longint b);
        if (a >= 0) return a / b;
        return -((-a + b - 1) / b);
    endfunction

    function automatic longint clamp16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic t_result trace_ray(input t_ray r);
        t_result res;
        longint o[3], d[3], pt[3];
        longint num, den, tdist;
        bit inner;
        res = '0;
        o[0] = sx(r.origin_x); o[1] = sx(r.origin_y); o[2] = sx(r.origin_z);
        d[0] = sx(r.ray_dx);   d[1] = sx(r.ray_dy);   d[2] = sx(r.ray_dz);
        den = -plane_at(quad_planes[CfgFace], d[0], d[1], d[2], 1'b0);
        if (den <= 0) return res;
        num = plane_at(quad_planes[CfgFace], o[0], o[1], o[2], 1'b1);
        if (num < 0) return res;
        tdist = (num * 256) / den;
        if (tdist >= longint'(r.max_distance)) return res;
        for (int i = 0; i < 3; i++) pt[i] = clamp16(o[i] + fdiv(d[i] * num, den));
        inner = 1'b1;
        for (int i = 1; i < PlaneCount; i++)
            if (plane_at(quad_planes[i], pt[0], pt[1], pt[2], 1'b1) < 0) inner = 1'b0;
        if (!inner) return res;
        res.hit = 1'b1;
        res.distance = tdist[14:0];
        res.hit_x = pt[0][15:0];
        res.hit_y = pt[1][15:0];
        res.hit_z = pt[2][15:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        err_count++;
    endtask

    // valid stays up across back-to-back requests; it drops only for a gap
    task automatic idle_burst();
        if (idle_on && $urandom_range(3) == 0) begin
            ray_ch.valid <= 1'b0;
            repeat ($urandom_range(7, 1)) @(posedge i_clk);
        end
    endtask

    task automatic send_ray(input t_ray r);
        idle_burst();
        ray_ch.valid <= 1'b1;
        ray_ch.data  <= r;
        do @(posedge i_clk); while (!ray_ch.ready);
        pending_hits.push_back(trace_ray(r));
    endtask

    task automatic write_plane(input logic [IdxW-1:0] idx, input logic [63:0] word);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= word;
        do @(posedge i_clk); while (!cfg_ch.ready);
        quad_planes[idx] = word;
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        ray_ch.valid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // square facing +z in the plane z = -zoff, x,y in [lo,hi] (Q8.8)
    function automatic logic [63:0] plane_word(input int nx, input int ny, input int nz,
                                               input int off);
        t_plane p;
        p.nx = 16'(nx); p.ny = 16'(ny); p.nz = 16'(nz); p.off = 16'(off);
        return p;
    endfunction

    task automatic load_square(input int lo, input int hi, input int zoff);
        write_plane(CfgFace,  plane_word(0, 0, 16384, zoff));
        write_plane(CfgEdge1, plane_word(16384, 0, 0, -lo));
        write_plane(CfgEdge2, plane_word(-16384, 0, 0, hi));
        write_plane(CfgEdge3, plane_word(0, 16384, 0, -lo));
        write_plane(CfgEdge4, plane_word(0, -16384, 0, hi));
    endtask

    function automatic t_ray aimed_ray(input int span);
        t_ray r;
        r.origin_x = 16'(int'($urandom_range(2 * span)) - span);
        r.origin_y = 16'(int'($urandom_range(2 * span)) - span);
        r.origin_z = 16'($urandom_range(4096, 1));
        r.ray_dx   = 16'(int'($urandom_range(512)) - 256);
        r.ray_dy   = 16'(int'($urandom_range(512)) - 256);
        r.ray_dz   = -$signed(16'($urandom_range(512, 1)));
        r.max_distance = 15'($urandom);
        return r;
    endfunction

    function automatic t_ray noise_ray();
        t_ray r;
        r = 111'({$urandom, $urandom, $urandom, $urandom});
        return r;
    endfunction

    task automatic test_reset_planes();
        // zero planes: den is zero, never a hit
        send_ray(noise_ray());
        send_ray('0);
        drain();
    endtask

    task automatic test_directed();
        t_ray r;
        load_square(-256, 256, 0);
        r = '0; r.origin_z = 256; r.ray_dz = -256; r.max_distance = 15'h7fff;
        send_ray(r);                                   // straight hit
        r.max_distance = 256; send_ray(r);             // distance equals bound
        r.max_distance = 257; send_ray(r);
        r.max_distance = 0; send_ray(r);               // zero range
        r.max_distance = 15'h7fff;
        r.ray_dz = 256; send_ray(r);                   // back facing
        r.ray_dz = 0; r.ray_dx = 256; send_ray(r);     // parallel
        r.ray_dx = 0; r.ray_dz = -256; r.origin_z = -256; send_ray(r); // behind
        r.origin_z = 0; send_ray(r);                   // on plane
        r.origin_z = 256; r.origin_x = 256; send_ray(r);  // on edge
        r.origin_x = 257; send_ray(r);                 // just outside
        r.origin_x = 16'sh7fff; r.origin_y = 16'sh8000; send_ray(r);
        r = '0; r.origin_z = 16'sh7fff; r.ray_dz = -1; r.ray_dx = 16'sh7fff;
        r.max_distance = 15'h7fff; send_ray(r);        // saturating point
        r.ray_dx = 16'sh8000; r.ray_dy = 16'sh8000; r.ray_dz = 16'sh8000; send_ray(r);
        r = '1; send_ray(r);
        drain();
        write_plane(CfgFace, 64'hffff_ffff_ffff_ffff);
        write_plane(CfgEdge1, 64'h8000_8000_8000_8000);
        write_plane(CfgEdge2, 64'h7fff_7fff_7fff_7fff);
        write_plane(CfgEdge3, '0);
        write_plane(CfgEdge4, 64'h7fff_8000_7fff_8000);
        for (int i = 0; i < 8; i++) send_ray(noise_ray());
        drain();
    endtask

    task automatic test_random();
        int cfgs[4][3] = '{'{-256, 256, 0}, '{-4096, 4096, 512}, '{-32768, 32767, -32768},
                           '{0, 16, 32767}};
        for (int k = 0; k < 4; k++) begin
            load_square(cfgs[k][0], cfgs[k][1], cfgs[k][2]);
            for (int i = 0; i < 250; i++)
                send_ray(($urandom_range(4) == 0) ? noise_ray() : aimed_ray(512));
            if (k == 1) begin
                // let the result path empty out before resuming
                ray_ch.valid <= 1'b0;
                while (pending_hits.size() != 0) @(posedge i_clk);
            end
            drain();
        end
        for (int i = 0; i < 4; i++)
            write_plane(3'(i), {$urandom, $urandom});
        write_plane(CfgEdge4, {$urandom, $urandom});
        for (int i = 0; i < 150; i++) send_ray(noise_ray());
        drain();
    endtask

    task automatic test_full_rate();
        idle_on = 1'b0;
        load_square(-1024, 1024, 256);
        for (int i = 0; i < 150; i++) send_ray(aimed_ray(1024));
        drain();
    endtask

    // result checker with random stalls
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (pending_hits.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0);
                end else begin
                    want = pending_hits.pop_front();
                    if (res_ch.data.hit != want.hit)
                        report_mismatch("hit", int'(res_ch.data.hit), int'(want.hit));
                    if (res_ch.data.distance != want.distance)
                        report_mismatch("distance", int'(res_ch.data.distance),
                                        int'(want.distance));
                    if (res_ch.data.hit_x != want.hit_x)
                        report_mismatch("hit_x", int'(res_ch.data.hit_x), int'(want.hit_x));
                    if (res_ch.data.hit_y != want.hit_y)
                        report_mismatch("hit_y", int'(res_ch.data.hit_y), int'(want.hit_y));
                    if (res_ch.data.hit_z != want.hit_z)
                        report_mismatch("hit_z", int'(res_ch.data.hit_z), int'(want.hit_z));
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                res_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(5) == 0) begin
                stall_left <= $urandom_range(6);
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((ray_ch.valid && ray_ch.ready) || (res_ch.valid && res_ch.ready) ||
            cfg_ch.valid || ray_ch.valid == 1'b0 && pending_hits.size() == 0)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 2000 && !done_flag) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        ray_ch.valid = 1'b0;
        ray_ch.data  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.wdata = '0;
        for (int i = 0; i < PlaneCount; i++) quad_planes[i] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_planes();
        test_directed();
        test_random();
        test_full_rate();
        done_flag = 1'b1;
        if (err_count == 0 && pending_hits.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
